@@ rtl/core/rmf_pkg.sv @@
package rmf_pkg;

    localparam int SAMPLE_W           = 16;
    localparam int SIZE_W             = 5;
    localparam int WINDOW_MAX_DEFAULT = 16;

    localparam logic [SIZE_W-1:0]   SIZE_RESET   = 5'd15;
    localparam logic [SAMPLE_W-1:0] STOPPER      = 16'd0;
    localparam logic [SAMPLE_W-1:0] STOPPER_SUBST = 16'd1;

    typedef struct packed {
        logic                load;
        logic                clear;
        logic [SAMPLE_W-1:0] value;
    } cell_ctrl_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                ge;
        logic                del_seen;
    } cell_link_t;

endpackage

@@ rtl/core/rmf_cell.sv @@
module rmf_cell #(
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rmf_pkg::cell_ctrl_t  ctrl,
    input  logic [IDX_W-1:0]     ins_slot,
    input  logic                 active,
    input  rmf_pkg::cell_link_t  left_link,
    input  logic [IDX_W-1:0]     left_slot,
    input  rmf_pkg::cell_link_t  right_link,
    input  logic [IDX_W-1:0]     right_slot,
    output rmf_pkg::cell_link_t  own_link,
    output logic [IDX_W-1:0]     own_slot
);

    logic [rmf_pkg::SAMPLE_W-1:0] value_reg;
    logic [rmf_pkg::SAMPLE_W-1:0] value_next;
    logic [IDX_W-1:0]             slot_reg;
    logic [IDX_W-1:0]             slot_next;
    logic                         ge;
    logic                         match;
    logic                         del_seen;
    logic                         prev_ge;

    assign ge       = active && (value_reg >= ctrl.value);
    assign match    = active && (slot_reg == ins_slot);
    assign del_seen = match || left_link.del_seen;
    assign prev_ge  = left_link.del_seen ? ge : left_link.ge;

    always_comb
    begin
        value_next = value_reg;
        slot_next  = slot_reg;
        if (!del_seen)
        begin
            if (!ge)
            begin
                if (left_link.ge)
                begin
                    value_next = ctrl.value;
                    slot_next  = ins_slot;
                end
                else
                begin
                    value_next = left_link.value;
                    slot_next  = left_slot;
                end
            end
        end
        else if (right_link.ge)
        begin
            value_next = right_link.value;
            slot_next  = right_slot;
        end
        else if (prev_ge)
        begin
            value_next = ctrl.value;
            slot_next  = ins_slot;
        end
        else if (left_link.del_seen)
        begin
            value_next = value_reg;
            slot_next  = slot_reg;
        end
        else
        begin
            value_next = left_link.value;
            slot_next  = left_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            slot_reg  <= IDX_W'(INDEX);
        end
        else if (ctrl.clear)
        begin
            value_reg <= '0;
            slot_reg  <= IDX_W'(INDEX);
        end
        else if (ctrl.load && active)
        begin
            value_reg <= value_next;
            slot_reg  <= slot_next;
        end
    end

    assign own_link.value    = value_reg;
    assign own_link.ge       = ge;
    assign own_link.del_seen = del_seen;
    assign own_slot          = slot_reg;

endmodule

@@ rtl/core/running_median_filter_core.sv @@
// Sliding-window median over the last window_size 16-bit samples (1 to WINDOW_MAX;
// 0 acts as 1, larger values as WINDOW_MAX). A sample of zero is taken as one. The
// window is a row of cells kept sorted by value; each transfer evicts the oldest
// sample and inserts the new one in the same cycle, and median then shows the
// (floor(N/2)+1)-th largest value. One sample is taken per cycle while the result
// side does not stall; a new sample waits only while a result is held by out_stall.
// The window reads as all zeros after reset and after every write to window_size;
// cfg_ready is always high and a write is accepted in the cycle it is made.
module running_median_filter_core #(
    parameter int WINDOW_MAX = rmf_pkg::WINDOW_MAX_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rmf_pkg::SAMPLE_W-1:0]  sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rmf_pkg::SAMPLE_W-1:0]  median,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rmf_pkg::SIZE_W-1:0]    cfg_data
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    logic [rmf_pkg::SIZE_W-1:0]   size_reg;
    logic [IDX_W-1:0]             oldest_reg;
    logic [IDX_W-1:0]             oldest_next;
    logic                         out_valid_reg;
    logic [CNT_W-1:0]             n_eff;
    logic [IDX_W-1:0]             mid;
    logic                         in_xfer;
    logic                         cfg_xfer;
    logic [rmf_pkg::SAMPLE_W-1:0] fixed_sample;
    rmf_pkg::cell_ctrl_t          ctrl;

    rmf_pkg::cell_link_t          links   [WINDOW_MAX];
    logic [IDX_W-1:0]             slots   [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]        active;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_xfer   = in_valid && !in_stall;

    always_comb
    begin
        if (size_reg == '0)
            n_eff = CNT_W'(1);
        else if (int'(size_reg) > WINDOW_MAX)
            n_eff = CNT_W'(WINDOW_MAX);
        else
            n_eff = CNT_W'(size_reg);
    end

    assign mid          = IDX_W'(n_eff >> 1);
    assign fixed_sample = (sample == rmf_pkg::STOPPER) ? rmf_pkg::STOPPER_SUBST : sample;

    always_comb
    begin
        if ((CNT_W'(oldest_reg) + CNT_W'(1)) >= n_eff)
            oldest_next = '0;
        else
            oldest_next = IDX_W'(CNT_W'(oldest_reg) + CNT_W'(1));
    end

    assign ctrl.load  = in_xfer;
    assign ctrl.clear = cfg_xfer;
    assign ctrl.value = fixed_sample;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++)
        begin : g_cell
            rmf_pkg::cell_link_t left_link;
            rmf_pkg::cell_link_t right_link;
            logic [IDX_W-1:0]    left_slot;
            logic [IDX_W-1:0]    right_slot;

            assign active[gi] = CNT_W'(gi) < n_eff;

            if (gi == 0)
            begin : g_head
                assign left_link.value    = '0;
                assign left_link.ge       = 1'b1;
                assign left_link.del_seen = 1'b0;
                assign left_slot          = '0;
            end
            else
            begin : g_mid_left
                assign left_link = links[gi-1];
                assign left_slot = slots[gi-1];
            end

            if (gi == WINDOW_MAX - 1)
            begin : g_tail
                assign right_link.value    = '0;
                assign right_link.ge       = 1'b0;
                assign right_link.del_seen = 1'b0;
                assign right_slot          = '0;
            end
            else
            begin : g_mid_right
                assign right_link = links[gi+1];
                assign right_slot = slots[gi+1];
            end

            rmf_cell #(
                .IDX_W (IDX_W),
                .INDEX (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .ins_slot   (oldest_reg),
                .active     (active[gi]),
                .left_link  (left_link),
                .left_slot  (left_slot),
                .right_link (right_link),
                .right_slot (right_slot),
                .own_link   (links[gi]),
                .own_slot   (slots[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= rmf_pkg::SIZE_RESET;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_xfer)
            begin
                size_reg   <= cfg_data;
                oldest_reg <= '0;
            end
            else if (in_xfer)
            begin
                oldest_reg <= oldest_next;
            end

            if (in_xfer)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign median    = links[mid].value;

endmodule
